FILE: rtl/gb2d_pkg.sv
// Shared types and constants for the streaming Gaussian smoothing filter.
// No dependencies; imported by gb2d_front, gb2d_queue, gb2d_back and the top level.
package gb2d_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 3;
    localparam int LS_DEPTH    = 16384;
    localparam int LS_AW       = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int ACC_W       = 46;
    localparam int PROD_W      = 34;
    localparam int TERM_W      = 42;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_RADIUS = 3'd2,
        CFG_WEIGHT_CENTER = 3'd3,
        CFG_WEIGHT_OFF1   = 3'd4,
        CFG_WEIGHT_OFF2   = 3'd5,
        CFG_WEIGHT_OFF3   = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [10:0] w;
        logic [12:0] h;
        logic [1:0]  rad;
    } geom_t;

    typedef logic [3:0][16:0] weights_t;

    typedef struct packed {
        logic [LS_AW-1:0] head;
        logic [LS_AW-1:0] cnt;
        logic [12:0]      row;
        logic [9:0]       col;
        logic             last;
    } job_t;

endpackage

FILE: rtl/gb2d_in_if.sv
// Input channel: valid/ready handshake with one pixel item.
// Depends on nothing.
interface gb2d_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel;

    modport source (output valid, action, pixel, input ready);
    modport sink (input valid, action, pixel, output ready);
endinterface

FILE: rtl/gb2d_out_if.sv
// Output channel: valid/ready handshake with one smoothed pixel.
// Depends on nothing.
interface gb2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] smoothed;
    logic       frame_end;

    modport source (output valid, smoothed, frame_end, input ready);
    modport sink (input valid, smoothed, frame_end, output ready);
endinterface

FILE: rtl/gb2d_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module gb2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/gb2d_front.sv
// Front end: accepts pixels, writes the history memory, tracks frame position
// and queues one job per output pixel. Depends on gb2d_pkg, gb2d_in_if.
module gb2d_front
    import gb2d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    gb2d_in_if.sink          in_ch,
    input  geom_t            geom,
    input  logic             restart,
    input  logic             q_full,
    output logic             push,
    output job_t             push_job,
    output logic             mem_we,
    output logic [LS_AW-1:0] mem_waddr,
    output logic [7:0]       mem_wdata
);

    logic [LS_AW-1:0] head_reg, head_next;
    logic [LS_AW-1:0] wcnt_reg, wcnt_next;
    logic [11:0]      lead_cnt_reg;
    logic [12:0]      row_reg;
    logic [9:0]       col_reg;
    logic [11:0]      lead;
    logic             accept;
    logic             fire;
    logic             last;
    logic             row_end;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    assign lead    = ({10'b0, geom.rad} * {1'b0, geom.w}) + {10'b0, geom.rad};
    assign fire    = accept && (lead_cnt_reg == lead);
    assign row_end = ({1'b0, col_reg} + 11'd1) >= geom.w;
    assign last    = row_end && (({1'b0, row_reg} + 14'd1) >= {1'b0, geom.h});

    assign head_next = head_reg + LS_AW'(1);
    assign wcnt_next = (&wcnt_reg) ? wcnt_reg : wcnt_reg + LS_AW'(1);

    assign mem_we    = accept;
    assign mem_waddr = head_next;
    assign mem_wdata = in_ch.action ? 8'd0 : in_ch.pixel;

    assign push          = fire;
    assign push_job.head = head_next;
    assign push_job.cnt  = wcnt_next;
    assign push_job.row  = row_reg;
    assign push_job.col  = col_reg;
    assign push_job.last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            wcnt_reg     <= '0;
            lead_cnt_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                head_reg <= head_next;
                wcnt_reg <= wcnt_next;
            end
            if (restart)
            begin
                lead_cnt_reg <= '0;
                row_reg      <= '0;
                col_reg      <= '0;
            end
            else if (fire)
            begin
                // advance output position; wrap to a new frame on its last pixel
                if (last)
                begin
                    lead_cnt_reg <= '0;
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                else if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 13'd1;
                end
                else
                begin
                    col_reg <= col_reg + 10'd1;
                end
            end
            else if (accept)
            begin
                lead_cnt_reg <= lead_cnt_reg + 12'd1;
            end
        end
    end

endmodule

FILE: rtl/gb2d_queue.sv
// Short job FIFO between the front end and the convolution back end.
// Depends on gb2d_pkg.
module gb2d_queue
    import gb2d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full    = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + (QUEUE_AW+1)'(1))
        else $error("queue count did not advance on push");

endmodule

FILE: rtl/gb2d_back.sv
// Back end: walks the kernel window of one job tap by tap, accumulates
// pixel times weight products, rounds, saturates and holds the result.
// Depends on gb2d_pkg, gb2d_out_if.
module gb2d_back
    import gb2d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  weights_t         weights,
    input  logic             q_empty,
    input  job_t             q_job,
    output logic             pop,
    output logic             mem_re,
    output logic [LS_AW-1:0] mem_raddr,
    input  logic [7:0]       mem_rdata,
    gb2d_out_if.source       out_ch
);

    back_state_t state_reg, state_next;

    job_t               job_reg;
    logic [2:0]         i_reg, j_reg;
    logic [LS_AW-1:0]   rowoff_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               b_v_reg, b_m_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               t_v_reg;
    logic [TERM_W-1:0]  term_reg;
    logic               out_v_reg;
    logic [7:0]         smooth_reg;
    logic               fe_reg;

    logic [2:0]         span;
    logic               last_col, last_tap;
    logic [LS_AW-1:0]   tap_dist;
    logic signed [14:0] tr;
    logic signed [11:0] tc;
    logic               tap_ok;
    logic [2:0]         ri, ci;
    logic [16:0]        wr, wc;
    logic [TERM_W-1:0]  term_mul;
    logic               load_out;
    logic [13:0]        q;
    logic [31:0]        frac;
    logic               round_up;
    logic [14:0]        q_rnd;
    logic [7:0]         q_sat;

    assign span     = {geom.rad, 1'b0};
    assign last_col = j_reg == span;
    assign last_tap = last_col && (i_reg == span);

    // tap (i,j) sits at row offset R-i and column offset R-j
    assign tap_dist = rowoff_reg + LS_AW'(j_reg);
    assign tr   = $signed({2'b00, job_reg.row}) + $signed({13'b0, geom.rad})
                - $signed({12'b0, i_reg});
    assign tc   = $signed({2'b00, job_reg.col}) + $signed({10'b0, geom.rad})
                - $signed({9'b0, j_reg});
    assign tap_ok = !tr[14] && (tr[13:0] < {1'b0, geom.h})
                 && !tc[11] && (tc[10:0] < geom.w)
                 && (tap_dist < job_reg.cnt);

    assign ri = (i_reg >= {1'b0, geom.rad}) ? i_reg - {1'b0, geom.rad}
                                            : {1'b0, geom.rad} - i_reg;
    assign ci = (j_reg >= {1'b0, geom.rad}) ? j_reg - {1'b0, geom.rad}
                                            : {1'b0, geom.rad} - j_reg;
    assign wr = weights[ri[1:0]];
    assign wc = weights[ci[1:0]];

    assign mem_re    = state_reg == BK_RUN;
    assign mem_raddr = job_reg.head - tap_dist;

    assign term_mul = {34'b0, mem_rdata} * {8'b0, prod_reg};

    assign q        = acc_reg[ACC_W-1:32];
    assign frac     = acc_reg[31:0];
    assign round_up = (frac > 32'h8000_0000) || ((frac == 32'h8000_0000) && q[0]);
    assign q_rnd    = {1'b0, q} + {14'b0, round_up};
    assign q_sat    = (q_rnd > 15'd255) ? 8'd255 : q_rnd[7:0];

    assign out_ch.valid     = out_v_reg;
    assign out_ch.smoothed  = smooth_reg;
    assign out_ch.frame_end = fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (last_tap)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!b_v_reg && !t_v_reg)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                // hold until the output register frees up
                if (!out_v_reg || out_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
        prod_reg <= {17'b0, wr} * {17'b0, wc};
        b_m_reg  <= tap_ok;
        term_reg <= b_m_reg ? term_mul : '0;
        if (load_out)
        begin
            smooth_reg <= q_sat;
            fe_reg     <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg      <= '0;
            j_reg      <= '0;
            rowoff_reg <= '0;
            acc_reg    <= '0;
            b_v_reg    <= 1'b0;
            t_v_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            b_v_reg <= state_reg == BK_RUN;
            t_v_reg <= b_v_reg;
            if (pop)
            begin
                i_reg      <= '0;
                j_reg      <= '0;
                rowoff_reg <= '0;
                acc_reg    <= '0;
            end
            else
            begin
                if (state_reg == BK_RUN)
                begin
                    if (last_col)
                    begin
                        j_reg      <= '0;
                        i_reg      <= i_reg + 3'd1;
                        rowoff_reg <= rowoff_reg + LS_AW'(geom.w);
                    end
                    else
                    begin
                        j_reg <= j_reg + 3'd1;
                    end
                end
                if (t_v_reg)
                begin
                    acc_reg <= acc_reg + {4'b0, term_reg};
                end
            end
            if (load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == BK_IDLE)
        else $error("job taken while busy");

    a_load_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |-> !load_out)
        else $error("pending result overwritten");

    a_pipe_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DONE) |-> (!b_v_reg && !t_v_reg))
        else $error("rounding before accumulation finished");

endmodule

FILE: rtl/gaussian_blur_2d_unit.sv
// Top level of the streaming Gaussian smoothing filter: configuration
// registers and wiring. Depends on gb2d_pkg, the channel interfaces,
// gb2d_front, gb2d_queue, gb2d_back and gb2d_ram.
//
// Usage:
//   in_ch carries raster-order pixels (action 0) and flush items (action 1,
//   a zero pixel). After an image of height*width pixels the host sends
//   radius*width+radius flush items. out_ch carries one smoothed pixel per
//   input item once the first radius*width+radius items of a frame are in;
//   frame_end marks the last pixel of the frame.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only
//   while idle. A geometry write restarts the frame; weights apply at once.
//   The back end takes a job only while idle and finishes its result
//   before it takes the next, since the window is walked one tap per
//   cycle through a single multiply-accumulate path and one read port of
//   the history memory.
//   The front end queues up to four jobs ahead of the back end.
//   Reset clears the counters and loads the default registers; the history
//   memory is not swept; taps on unwritten history add zero.
//   A stalled receiver holds the result register; the back end then waits,
//   the queue fills and in_ch.ready drops.
module gaussian_blur_2d_unit
    import gb2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gb2d_in_if.sink     in_ch,
    gb2d_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  radius_reg;
    weights_t    weights_reg;
    geom_t       geom;
    logic        restart;

    logic             q_full, q_empty, push, pop;
    job_t             push_job, pop_job;
    logic             mem_we, mem_re;
    logic [LS_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata, mem_rdata;

    assign restart = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH)
                             || (cfg_index == CFG_IMAGE_HEIGHT)
                             || (cfg_index == CFG_KERNEL_RADIUS));

    always_comb
    begin
        geom.w = width_reg;
        if (width_reg == 11'd0)
        begin
            geom.w = 11'd1;
        end
        else if (width_reg > 11'(MAX_WIDTH))
        begin
            geom.w = 11'(MAX_WIDTH);
        end
        geom.h   = (height_reg == 13'd0) ? 13'd1 : height_reg;
        geom.rad = (radius_reg > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 11'd512;
            height_reg     <= 13'd512;
            radius_reg     <= 2'd1;
            weights_reg[0] <= 17'd29614;
            weights_reg[1] <= 17'd17961;
            weights_reg[2] <= 17'd0;
            weights_reg[3] <= 17'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg      <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:  height_reg     <= cfg_data[12:0];
                CFG_KERNEL_RADIUS: radius_reg     <= cfg_data[1:0];
                CFG_WEIGHT_CENTER: weights_reg[0] <= cfg_data;
                CFG_WEIGHT_OFF1:   weights_reg[1] <= cfg_data;
                CFG_WEIGHT_OFF2:   weights_reg[2] <= cfg_data;
                CFG_WEIGHT_OFF3:   weights_reg[3] <= cfg_data;
                default:           ;
            endcase
        end
    end

    gb2d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .geom      (geom),
        .restart   (restart),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    gb2d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    gb2d_ram #(
        .WIDTH (8),
        .DEPTH (LS_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gb2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .weights   (weights_reg),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (pop),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_ch    (out_ch)
    );

endmodule
